// File: hdl/urr_pkg.sv
// urr_pkg: shared types, register indexes, reset values and character codes
// for the ultrasonic range reporter; no dependencies
package urr_pkg;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 16;

  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

  localparam cfg_index_t REG_PERIOD_COUNTS  = 3'd0;
  localparam cfg_index_t REG_SHOT_INTERVAL  = 3'd1;
  localparam cfg_index_t REG_TRIGGER_COUNTS = 3'd2;
  localparam cfg_index_t REG_SCALE_FACTOR   = 3'd3;
  localparam cfg_index_t REG_TIMEOUT_VALUE  = 3'd4;
  localparam cfg_index_t REG_BLINK_PERIOD   = 3'd5;

  localparam logic [15:0] RST_PERIOD_COUNTS  = 16'd50000;
  localparam logic [7:0]  RST_SHOT_INTERVAL  = 8'd50;
  localparam logic [7:0]  RST_TRIGGER_COUNTS = 8'd10;
  localparam logic [7:0]  RST_SCALE_FACTOR   = 8'd87;
  localparam logic [15:0] RST_TIMEOUT_VALUE  = 16'd1000;
  localparam logic [3:0]  RST_BLINK_PERIOD   = 4'd10;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_CR   = 8'h0D;

  localparam logic [15:0] DIST_MAX = 16'hFFFF;

  // position of the units digit and the carriage return in a report
  localparam logic [2:0] IDX_UNITS = 3'd4;
  localparam logic [2:0] IDX_CR    = 3'd5;

  typedef struct packed {
    logic [15:0] period_counts;
    logic [7:0]  shot_interval;
    logic [7:0]  trigger_counts;
    logic [7:0]  scale_factor;
    logic [15:0] timeout_value;
    logic [3:0]  blink_period;
  } cfg_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_RISE,
    PH_FALL
  } phase_t;

  typedef enum logic [1:0] {
    BK_LOAD,
    BK_MUL,
    BK_DIGIT
  } back_state_t;

  // per-tick summary handed from front to back
  typedef struct packed {
    logic trig;
    logic led;
    logic report;
    logic timeout;
  } tick_info_t;

  // decimal weight of the four leading digits
  function automatic logic [16:0] pow10(input logic [1:0] pos);
    logic [16:0] w;
    case (pos)
      2'd0:    w = 17'd10000;
      2'd1:    w = 17'd1000;
      2'd2:    w = 17'd100;
      default: w = 17'd10;
    endcase
    return w;
  endfunction

endpackage

// File: hdl/urr_in_if.sv
// urr_in_if: tick channel carrying the echo pin level
// depends on nothing
interface urr_in_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink   (input valid, input echo_level, output ready);
endinterface

// File: hdl/urr_out_if.sv
// urr_out_if: result channel, one word per report character or per tick
// depends on nothing
interface urr_out_if;
  logic       valid;
  logic       ready;
  logic       trigger_out;
  logic       led_on;
  logic       char_valid;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output trigger_out, output led_on, output char_valid,
                  output char_code, output last, input ready);
  modport sink   (input valid, input trigger_out, input led_on, input char_valid,
                  input char_code, input last, output ready);
endinterface

// File: hdl/urr_cfg_if.sv
// urr_cfg_if: register write channel
// depends on urr_pkg for index and data widths
interface urr_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [urr_pkg::CFG_INDEX_WIDTH-1:0] index;
  logic [urr_pkg::CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/urr_front.sv
// urr_front: tick counting, shot sequencing and echo timing, one tick a cycle unless the queue is full
// depends on urr_pkg and urr_in_if
module urr_front #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  urr_pkg::cfg_t          cfg,
  urr_in_if.sink                 tick_in,
  input  logic                   q_full,
  output logic                   q_push,
  output urr_pkg::tick_info_t    info,
  output logic [TIMER_WIDTH-1:0] width
);
  import urr_pkg::*;

  localparam int CW = (TIMER_WIDTH + 1 > 16) ? TIMER_WIDTH + 1 : 16;

  logic [TIMER_WIDTH-1:0] tick, tick_next;
  logic [7:0]             period_count, period_count_next;
  logic [3:0]             blink_count, blink_count_next;
  phase_t                 phase, phase_next;
  logic [7:0]             trigger_left, trigger_left_next;
  logic [TIMER_WIDTH-1:0] echo_start, echo_start_next;

  logic       accept;
  logic       echo;
  logic       fire;
  logic       period_end;
  logic       meas;
  phase_t     ph_start, ph_mid;
  logic [7:0] tl_start;
  logic [7:0] pc_base;
  logic [3:0] bp;

  assign tick_in.ready = !q_full;
  assign accept        = tick_in.valid && !q_full;
  assign q_push        = accept;
  assign echo          = tick_in.echo_level;

  // shot fires on the first tick of a period once the count is reached
  assign fire       = (tick == '0) && (period_count >= cfg.shot_interval);
  assign ph_start   = fire ? ((cfg.trigger_counts != 8'd0) ? PH_TRIG : PH_RISE) : phase;
  assign tl_start   = fire ? cfg.trigger_counts : trigger_left;
  assign pc_base    = fire ? 8'd0 : period_count;
  assign period_end = (CW'(tick) + CW'(1) >= CW'(cfg.period_counts)) || (tick == '1);
  assign bp         = (cfg.blink_period == 4'd0) ? 4'd1 : cfg.blink_period;

  // outputs of this tick
  always_comb begin
    meas         = (ph_start == PH_FALL) && !echo;
    info.trig    = (ph_start == PH_TRIG);
    info.led     = (blink_count == 4'd0);
    info.timeout = period_end && (ph_start != PH_IDLE) && !meas;
    info.report  = meas || info.timeout;
    width        = tick - echo_start;
  end

  // next state
  always_comb begin
    ph_mid            = ph_start;
    trigger_left_next = tl_start;
    echo_start_next   = echo_start;
    case (ph_start)
      PH_TRIG: begin
        trigger_left_next = tl_start - 8'd1;
        ph_mid            = (tl_start == 8'd1) ? PH_RISE : PH_TRIG;
      end
      PH_RISE: begin
        if (echo) begin
          echo_start_next = tick;
          ph_mid          = PH_FALL;
        end
      end
      PH_FALL: begin
        if (!echo) begin
          ph_mid = PH_IDLE;
        end
      end
      default: ph_mid = PH_IDLE;
    endcase

    if (period_end) begin
      phase_next        = PH_IDLE;
      tick_next         = '0;
      period_count_next = pc_base + 8'd1;
      blink_count_next  = ({1'b0, blink_count} + 5'd1 >= {1'b0, bp}) ? 4'd0
                                                                      : blink_count + 4'd1;
    end else begin
      phase_next        = ph_mid;
      tick_next         = tick + TIMER_WIDTH'(1);
      period_count_next = pc_base;
      blink_count_next  = blink_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick         <= '0;
      period_count <= '0;
      blink_count  <= '0;
      phase        <= PH_IDLE;
      trigger_left <= '0;
      echo_start   <= '0;
    end else if (accept) begin
      tick         <= tick_next;
      period_count <= period_count_next;
      blink_count  <= blink_count_next;
      phase        <= phase_next;
      trigger_left <= trigger_left_next;
      echo_start   <= echo_start_next;
    end
  end

endmodule

// File: hdl/urr_queue.sv
// urr_queue: short first-in first-out buffer between front and back
// depends on nothing
module urr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: hdl/urr_back.sv
// urr_back: scales the echo width and spells each report as ascii words
// depends on urr_pkg and urr_out_if
module urr_back #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  urr_pkg::cfg_t          cfg,
  input  logic                   q_empty,
  input  urr_pkg::tick_info_t    q_info,
  input  logic [TIMER_WIDTH-1:0] q_width,
  output logic                   q_pop,
  urr_out_if.source              result_out
);
  import urr_pkg::*;

  localparam int PW = TIMER_WIDTH + 8;

  back_state_t            state, state_next;
  logic                   trig_q, led_q;
  logic [TIMER_WIDTH-1:0] width_q;
  logic [15:0]            val;
  logic [2:0]             idx;

  logic       o_valid, o_trig, o_led, o_cv, o_last;
  logic [7:0] o_code;

  logic       out_free;
  logic       load_out;
  logic       n_trig, n_led, n_cv, n_last;
  logic [7:0] n_code;

  logic [PW-1:0]          prod;
  logic [TIMER_WIDTH-1:0] prod_sh;
  logic [15:0]            range_mm;
  logic [16:0]            pw;
  logic [16:0]            sub;
  logic [3:0]             dig;
  logic [16:0]            rem;

  assign out_free = !o_valid || result_out.ready;
  assign q_pop    = (state == BK_LOAD) && !q_empty && out_free;

  // scaled distance, saturated to 16 bits
  assign prod     = PW'(width_q) * PW'(cfg.scale_factor);
  assign prod_sh  = prod[PW-1:8];
  assign range_mm = (prod_sh > TIMER_WIDTH'(DIST_MAX)) ? DIST_MAX : 16'(prod_sh);

  // one decimal digit per word
  always_comb begin
    pw  = pow10(idx[1:0]);
    dig = 4'd0;
    sub = 17'd0;
    for (int d = 1; d <= 9; d++) begin
      if ({1'b0, val} >= 17'(d) * pw) begin
        dig = 4'(d);
        sub = 17'(d) * pw;
      end
    end
    rem = {1'b0, val} - sub;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_LOAD: begin
        if (q_pop && q_info.report) begin
          state_next = q_info.timeout ? BK_DIGIT : BK_MUL;
        end
      end
      BK_MUL:   state_next = BK_DIGIT;
      BK_DIGIT: begin
        if (out_free && idx == IDX_CR) begin
          state_next = BK_LOAD;
        end
      end
      default:  state_next = BK_LOAD;
    endcase
  end

  // word to load into the output register
  always_comb begin
    load_out = 1'b0;
    n_trig   = trig_q;
    n_led    = led_q;
    n_cv     = 1'b1;
    n_code   = CHAR_CR;
    n_last   = 1'b0;
    case (state)
      BK_LOAD: begin
        if (q_pop && !q_info.report) begin
          load_out = 1'b1;
          n_trig   = q_info.trig;
          n_led    = q_info.led;
          n_cv     = 1'b0;
          n_code   = 8'd0;
          n_last   = 1'b1;
        end
      end
      BK_DIGIT: begin
        load_out = out_free;
        if (idx < IDX_UNITS) begin
          n_code = CHAR_ZERO + {4'd0, dig};
        end else if (idx == IDX_UNITS) begin
          n_code = CHAR_ZERO + {4'd0, val[3:0]};
        end else begin
          n_code = CHAR_CR;
          n_last = 1'b1;
        end
      end
      default: load_out = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_LOAD;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        o_valid <= 1'b1;
      end else if (result_out.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      trig_q  <= q_info.trig;
      led_q   <= q_info.led;
      width_q <= q_width;
      val     <= cfg.timeout_value;
      idx     <= 3'd0;
    end else if (state == BK_MUL) begin
      val <= range_mm;
    end else if (state == BK_DIGIT && out_free) begin
      if (idx < IDX_UNITS) begin
        val <= rem[15:0];
      end
      idx <= idx + 3'd1;
    end
    if (load_out) begin
      o_trig <= n_trig;
      o_led  <= n_led;
      o_cv   <= n_cv;
      o_code <= n_code;
      o_last <= n_last;
    end
  end

  assign result_out.valid       = o_valid;
  assign result_out.trigger_out = o_trig;
  assign result_out.led_on      = o_led;
  assign result_out.char_valid  = o_cv;
  assign result_out.char_code   = o_code;
  assign result_out.last        = o_last;

endmodule

// File: hdl/ultrasonic_range_reporter.sv
// ultrasonic_range_reporter: tick-driven ultrasonic ranger with ascii reports
// path: a tick is taken into the queue, then loaded into the output register once the back is free
// throughput: one tick a cycle; a report keeps the back busy for all of its steps
// (load, scale multiply unless timed out, six characters); the 4-deep queue holds
// up to four ticks meanwhile, after that the tick input stalls until it drains
// reset: synchronous; counters cleared, registers back to their default values
module ultrasonic_range_reporter #(
  parameter int TIMER_WIDTH = 16
) (
  input logic       clk,
  input logic       rst,
  urr_cfg_if.sink   cfg,
  urr_in_if.sink    tick_in,
  urr_out_if.source result_out
);
  import urr_pkg::*;

  localparam int QUEUE_DEPTH = 4;
  localparam int QW          = $bits(tick_info_t) + TIMER_WIDTH;

  cfg_t cfg_regs;

  // queue between front and back
  logic                   q_push, q_pop, q_full, q_empty;
  logic [QW-1:0]          q_wdata, q_rdata;
  tick_info_t             f_info, q_info;
  logic [TIMER_WIDTH-1:0] f_width, q_width;

  // register writes are always taken; unknown indexes fall through
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.period_counts  <= RST_PERIOD_COUNTS;
      cfg_regs.shot_interval  <= RST_SHOT_INTERVAL;
      cfg_regs.trigger_counts <= RST_TRIGGER_COUNTS;
      cfg_regs.scale_factor   <= RST_SCALE_FACTOR;
      cfg_regs.timeout_value  <= RST_TIMEOUT_VALUE;
      cfg_regs.blink_period   <= RST_BLINK_PERIOD;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PERIOD_COUNTS:  cfg_regs.period_counts  <= cfg.data;
        REG_SHOT_INTERVAL:  cfg_regs.shot_interval  <= cfg.data[7:0];
        REG_TRIGGER_COUNTS: cfg_regs.trigger_counts <= cfg.data[7:0];
        REG_SCALE_FACTOR:   cfg_regs.scale_factor   <= cfg.data[7:0];
        REG_TIMEOUT_VALUE:  cfg_regs.timeout_value  <= cfg.data;
        REG_BLINK_PERIOD:   cfg_regs.blink_period   <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  // front: one tick per cycle, stalls only when the queue is full
  urr_front #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_regs),
    .tick_in (tick_in),
    .q_full  (q_full),
    .q_push  (q_push),
    .info    (f_info),
    .width   (f_width)
  );

  assign q_wdata            = {f_info, f_width};
  assign {q_info, q_width}  = q_rdata;

  urr_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // back: scaling, digit split and the output register
  urr_back #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_regs),
    .q_empty    (q_empty),
    .q_info     (q_info),
    .q_width    (q_width),
    .q_pop      (q_pop),
    .result_out (result_out)
  );

endmodule

// File: hdl/urr_checker.sv
// urr_checker: port-level checks on the range reporter, bound to the top level
// depends on urr_pkg and ultrasonic_range_reporter
module urr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_char_valid,
  input logic [7:0] out_char_code,
  input logic       out_last
);
  import urr_pkg::*;

  // a stalled word stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a tick without a report is a single word
  a_plain_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_char_valid |-> out_last)
    else $error("plain tick word without last");

  // a report always ends on the carriage return
  a_cr_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_char_valid && out_last |-> out_char_code == CHAR_CR)
    else $error("report ends on a character other than cr");

  // nothing is offered straight after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind ultrasonic_range_reporter urr_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (result_out.valid),
  .out_ready      (result_out.ready),
  .out_char_valid (result_out.char_valid),
  .out_char_code  (result_out.char_code),
  .out_last       (result_out.last)
);
